// ===== design/fdr_pkg.sv =====
// Shared constants and transfer structures of the dielectric reflectance unit.
// Used by every module of the block; depends on nothing.
package fdr_pkg;

   localparam int IdxW    = 16;
   localparam int CosW    = 16;
   localparam int MagW    = 15;
   localparam int Frac28  = 28;
   localparam int Sq28W   = Frac28 + 1;
   localparam int SqIdxW  = 2 * IdxW;
   localparam int ProdW   = SqIdxW + Frac28;
   localparam int QtW     = Frac28 + 1;
   localparam int ResW    = QtW + 1;
   localparam int CtW     = MagW;
   localparam int AbW     = IdxW + MagW;
   localparam int DenW    = AbW + 1;
   localparam int Frac24  = 24;
   localparam int RqW     = Frac24 + 1;
   localparam int DivW    = DenW + RqW - 1;
   localparam int SqW     = 2 * RqW;
   localparam int SumW    = SqW + 1;
   localparam int RndPos  = 33;
   localparam int RndShift = 34;
   localparam int OutW    = 16;
   localparam int AddrW   = 3;
   localparam int DataW   = 32;

   localparam logic signed [CosW-1:0] CosPosOne = 16'sh4000;
   localparam logic signed [CosW-1:0] CosNegOne = 16'shC000;
   localparam logic [MagW-1:0]  MagOne  = 15'h4000;
   localparam logic [Sq28W-1:0] S2One   = 29'h1000_0000;
   localparam logic [RqW-1:0]   QOne    = 25'h100_0000;
   localparam logic [OutW-1:0]  OneQ15  = 16'h8000;
   localparam logic [IdxW-1:0]  IndexReset = 16'h1000;

   localparam logic RegIncident = 1'b0;
   localparam logic RegTransmit = 1'b1;

   typedef struct packed {
      logic              valid;
      logic              tir;
      logic [ProdW-1:0]  num;
      logic [SqIdxW-1:0] ntsq;
      logic [MagW-1:0]   c;
      logic [IdxW-1:0]   ni;
      logic [IdxW-1:0]   nt;
   } front_type;

   typedef struct packed {
      logic            valid;
      logic            tir;
      logic [CtW-1:0]  ct;
      logic [MagW-1:0] c;
      logic [IdxW-1:0] ni;
      logic [IdxW-1:0] nt;
   } cos_type;

   typedef struct packed {
      logic            valid;
      logic            tir;
      logic [OutW-1:0] refl;
   } result_type;

endpackage

// ===== design/fdr_front.sv =====
// Front stages: cosine clamp, index swap, squares and the total reflection test.
// Depends on fdr_pkg.
module fdr_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              en,
   input  logic                              in_valid,
   input  logic signed [fdr_pkg::CosW-1:0]   cos_in,
   input  logic [fdr_pkg::IdxW-1:0]          index_incident,
   input  logic [fdr_pkg::IdxW-1:0]          index_transmit,
   output fdr_pkg::front_type                front
);

   logic                          neg;
   logic signed [fdr_pkg::CosW-1:0] negv;
   logic [fdr_pkg::MagW-1:0]      c1_in;
   logic [fdr_pkg::IdxW-1:0]      ni1_in, nt1_in;

   logic                          v1_ff;
   logic [fdr_pkg::MagW-1:0]      c1_ff;
   logic [fdr_pkg::IdxW-1:0]      ni1_ff, nt1_ff;

   logic [2*fdr_pkg::MagW-1:0]    csq;
   logic [fdr_pkg::Sq28W-1:0]     s2_in;
   logic [fdr_pkg::SqIdxW-1:0]    nisq2_in, ntsq2_in;

   logic                          v2_ff;
   logic [fdr_pkg::Sq28W-1:0]     s2_ff;
   logic [fdr_pkg::SqIdxW-1:0]    nisq2_ff, ntsq2_ff;
   logic [fdr_pkg::MagW-1:0]      c2_ff;
   logic [fdr_pkg::IdxW-1:0]      ni2_ff, nt2_ff;

   logic [fdr_pkg::Sq28W+fdr_pkg::SqIdxW-1:0] lprod;
   logic [fdr_pkg::ProdW-1:0]     lhs3_in, rhs3_in;

   logic                          v3_ff;
   logic [fdr_pkg::ProdW-1:0]     lhs3_ff, rhs3_ff;
   logic [fdr_pkg::SqIdxW-1:0]    ntsq3_ff;
   logic [fdr_pkg::MagW-1:0]      c3_ff;
   logic [fdr_pkg::IdxW-1:0]      ni3_ff, nt3_ff;

   fdr_pkg::front_type            front_in, front_ff;

   always_comb begin
      neg  = cos_in[fdr_pkg::CosW-1];
      negv = -cos_in;
      if (neg) begin
         if (cos_in < fdr_pkg::CosNegOne) begin
            c1_in = fdr_pkg::MagOne;
         end else begin
            c1_in = negv[fdr_pkg::MagW-1:0];
         end
         ni1_in = index_transmit;
         nt1_in = index_incident;
      end else begin
         if (cos_in > fdr_pkg::CosPosOne) begin
            c1_in = fdr_pkg::MagOne;
         end else begin
            c1_in = cos_in[fdr_pkg::MagW-1:0];
         end
         ni1_in = index_incident;
         nt1_in = index_transmit;
      end
   end

   always_comb begin
      csq      = c1_ff * c1_ff;
      s2_in    = fdr_pkg::S2One - csq[fdr_pkg::Sq28W-1:0];
      nisq2_in = ni1_ff * ni1_ff;
      ntsq2_in = nt1_ff * nt1_ff;
   end

   always_comb begin
      lprod   = s2_ff * nisq2_ff;
      lhs3_in = lprod[fdr_pkg::ProdW-1:0];
      rhs3_in = {ntsq2_ff, {fdr_pkg::Frac28{1'b0}}};
   end

   always_comb begin
      front_in.valid = v3_ff;
      front_in.tir   = (lhs3_ff >= rhs3_ff);
      front_in.num   = front_in.tir ? '0 : (rhs3_ff - lhs3_ff);
      front_in.ntsq  = ntsq3_ff;
      front_in.c     = c3_ff;
      front_in.ni    = ni3_ff;
      front_in.nt    = nt3_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff          <= 1'b0;
         v2_ff          <= 1'b0;
         v3_ff          <= 1'b0;
         front_ff.valid <= 1'b0;
      end else if (en) begin
         v1_ff    <= in_valid;
         c1_ff    <= c1_in;
         ni1_ff   <= ni1_in;
         nt1_ff   <= nt1_in;
         v2_ff    <= v1_ff;
         s2_ff    <= s2_in;
         nisq2_ff <= nisq2_in;
         ntsq2_ff <= ntsq2_in;
         c2_ff    <= c1_ff;
         ni2_ff   <= ni1_ff;
         nt2_ff   <= nt1_ff;
         v3_ff    <= v2_ff;
         lhs3_ff  <= lhs3_in;
         rhs3_ff  <= rhs3_in;
         ntsq3_ff <= ntsq2_ff;
         c3_ff    <= c2_ff;
         ni3_ff   <= ni2_ff;
         nt3_ff   <= nt2_ff;
         front_ff <= front_in;
      end
   end

   assign front = front_ff;

endmodule

// ===== design/fdr_transcos.sv =====
// Transmitted cosine: a bit-per-stage divider followed by a pipelined square root.
// Depends on fdr_pkg.
module fdr_transcos (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  fdr_pkg::front_type front,
   output fdr_pkg::cos_type   cos
);

   typedef struct packed {
      logic                       valid;
      logic                       tir;
      logic [fdr_pkg::ProdW-1:0]  rem;
      logic [fdr_pkg::QtW-1:0]    quo;
      logic [fdr_pkg::SqIdxW-1:0] ntsq;
      logic [fdr_pkg::MagW-1:0]   c;
      logic [fdr_pkg::IdxW-1:0]   ni;
      logic [fdr_pkg::IdxW-1:0]   nt;
   } div_type;

   typedef struct packed {
      logic                       valid;
      logic                       tir;
      logic [fdr_pkg::QtW-1:0]    v;
      logic [fdr_pkg::ResW-1:0]   res;
      logic [fdr_pkg::MagW-1:0]   c;
      logic [fdr_pkg::IdxW-1:0]   ni;
      logic [fdr_pkg::IdxW-1:0]   nt;
   } root_type;

   div_type  div_src [fdr_pkg::QtW+1];
   div_type  div_in  [fdr_pkg::QtW];
   div_type  div_ff  [fdr_pkg::QtW];
   root_type rt_src  [fdr_pkg::CtW+1];
   root_type rt_in   [fdr_pkg::CtW];
   root_type rt_ff   [fdr_pkg::CtW];

   assign div_src[0] = '{valid: front.valid, tir: front.tir, rem: front.num,
                         quo: '0, ntsq: front.ntsq, c: front.c,
                         ni: front.ni, nt: front.nt};

   for (genvar k = 0; k < fdr_pkg::QtW; k++) begin : g_div
      logic [fdr_pkg::ProdW-1:0] trial;
      assign div_src[k+1] = div_ff[k];
      always_comb begin
         trial     = fdr_pkg::ProdW'(div_src[k].ntsq) << (fdr_pkg::QtW - 1 - k);
         div_in[k] = div_src[k];
         if (div_src[k].rem >= trial) begin
            div_in[k].rem                     = div_src[k].rem - trial;
            div_in[k].quo[fdr_pkg::QtW-1-k]   = 1'b1;
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            div_ff[k].valid <= 1'b0;
         end else if (en) begin
            div_ff[k] <= div_in[k];
         end
      end
   end

   assign rt_src[0] = '{valid: div_ff[fdr_pkg::QtW-1].valid,
                        tir: div_ff[fdr_pkg::QtW-1].tir,
                        v: div_ff[fdr_pkg::QtW-1].quo, res: '0,
                        c: div_ff[fdr_pkg::QtW-1].c,
                        ni: div_ff[fdr_pkg::QtW-1].ni,
                        nt: div_ff[fdr_pkg::QtW-1].nt};

   for (genvar j = 0; j < fdr_pkg::CtW; j++) begin : g_root
      logic [fdr_pkg::ResW-1:0] rbit;
      logic [fdr_pkg::ResW-1:0] tsum;
      assign rt_src[j+1] = rt_ff[j];
      always_comb begin
         rbit     = fdr_pkg::ResW'(1) << (2 * (fdr_pkg::CtW - 1 - j));
         tsum     = rt_src[j].res + rbit;
         rt_in[j] = rt_src[j];
         if (fdr_pkg::ResW'(rt_src[j].v) >= tsum) begin
            rt_in[j].v   = rt_src[j].v - tsum[fdr_pkg::QtW-1:0];
            rt_in[j].res = (rt_src[j].res >> 1) + rbit;
         end else begin
            rt_in[j].res = rt_src[j].res >> 1;
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            rt_ff[j].valid <= 1'b0;
         end else if (en) begin
            rt_ff[j] <= rt_in[j];
         end
      end
   end

   assign cos = '{valid: rt_ff[fdr_pkg::CtW-1].valid, tir: rt_ff[fdr_pkg::CtW-1].tir,
                  ct: rt_ff[fdr_pkg::CtW-1].res[fdr_pkg::CtW-1:0],
                  c: rt_ff[fdr_pkg::CtW-1].c, ni: rt_ff[fdr_pkg::CtW-1].ni,
                  nt: rt_ff[fdr_pkg::CtW-1].nt};

endmodule

// ===== design/fdr_ratio.sv =====
// Amplitude ratios: products, two parallel pipelined dividers, squares and the mean.
// Depends on fdr_pkg.
module fdr_ratio (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  fdr_pkg::cos_type    cos,
   output fdr_pkg::result_type result
);

   typedef struct packed {
      logic                      valid;
      logic                      tir;
      logic [fdr_pkg::DivW-1:0]  rem_s;
      logic [fdr_pkg::DivW-1:0]  rem_p;
      logic [fdr_pkg::DenW-1:0]  den_s;
      logic [fdr_pkg::DenW-1:0]  den_p;
      logic [fdr_pkg::RqW-1:0]   quo_s;
      logic [fdr_pkg::RqW-1:0]   quo_p;
   } div_type;

   logic                      vp_ff, tp_ff;
   logic [fdr_pkg::AbW-1:0]   pa_ff, pb_ff, pc_ff, pd_ff;

   logic [fdr_pkg::AbW-1:0]   diff_s_in, diff_p_in;
   logic [fdr_pkg::DenW-1:0]  den_s_in, den_p_in;
   logic                      vd_ff, td_ff;
   logic [fdr_pkg::AbW-1:0]   diff_s_ff, diff_p_ff;
   logic [fdr_pkg::DenW-1:0]  den_s_ff, den_p_ff;

   div_type div_src [fdr_pkg::RqW+1];
   div_type div_in  [fdr_pkg::RqW];
   div_type div_ff  [fdr_pkg::RqW];

   logic [fdr_pkg::RqW-1:0]   qs, qp;
   logic                      vq_ff, tq_ff;
   logic [fdr_pkg::SqW-1:0]   sqs_ff, sqp_ff;

   logic [fdr_pkg::SumW-1:0]  total;
   logic [fdr_pkg::SumW-fdr_pkg::RndShift-1:0] rnd;
   fdr_pkg::result_type       result_in, result_ff;

   always_comb begin
      diff_s_in = (pa_ff > pb_ff) ? (pa_ff - pb_ff) : (pb_ff - pa_ff);
      diff_p_in = (pc_ff > pd_ff) ? (pc_ff - pd_ff) : (pd_ff - pc_ff);
      den_s_in  = fdr_pkg::DenW'(pa_ff) + fdr_pkg::DenW'(pb_ff);
      den_p_in  = fdr_pkg::DenW'(pc_ff) + fdr_pkg::DenW'(pd_ff);
   end

   assign div_src[0] = '{valid: vd_ff, tir: td_ff,
                         rem_s: fdr_pkg::DivW'(diff_s_ff) << fdr_pkg::Frac24,
                         rem_p: fdr_pkg::DivW'(diff_p_ff) << fdr_pkg::Frac24,
                         den_s: den_s_ff, den_p: den_p_ff, quo_s: '0, quo_p: '0};

   for (genvar k = 0; k < fdr_pkg::RqW; k++) begin : g_div
      logic [fdr_pkg::DivW-1:0] trial_s, trial_p;
      assign div_src[k+1] = div_ff[k];
      always_comb begin
         trial_s   = fdr_pkg::DivW'(div_src[k].den_s) << (fdr_pkg::RqW - 1 - k);
         trial_p   = fdr_pkg::DivW'(div_src[k].den_p) << (fdr_pkg::RqW - 1 - k);
         div_in[k] = div_src[k];
         if (div_src[k].rem_s >= trial_s) begin
            div_in[k].rem_s                   = div_src[k].rem_s - trial_s;
            div_in[k].quo_s[fdr_pkg::RqW-1-k] = 1'b1;
         end
         if (div_src[k].rem_p >= trial_p) begin
            div_in[k].rem_p                   = div_src[k].rem_p - trial_p;
            div_in[k].quo_p[fdr_pkg::RqW-1-k] = 1'b1;
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            div_ff[k].valid <= 1'b0;
         end else if (en) begin
            div_ff[k] <= div_in[k];
         end
      end
   end

   always_comb begin
      qs = (div_ff[fdr_pkg::RqW-1].den_s == '0) ? fdr_pkg::QOne
                                                : div_ff[fdr_pkg::RqW-1].quo_s;
      qp = (div_ff[fdr_pkg::RqW-1].den_p == '0) ? fdr_pkg::QOne
                                                : div_ff[fdr_pkg::RqW-1].quo_p;
   end

   always_comb begin
      total = fdr_pkg::SumW'(sqs_ff) + fdr_pkg::SumW'(sqp_ff)
            + (fdr_pkg::SumW'(1) << fdr_pkg::RndPos);
      rnd   = total[fdr_pkg::SumW-1:fdr_pkg::RndShift];
      result_in.valid = vq_ff;
      result_in.tir   = tq_ff;
      if (tq_ff || rnd > (fdr_pkg::SumW-fdr_pkg::RndShift)'(fdr_pkg::OneQ15)) begin
         result_in.refl = fdr_pkg::OneQ15;
      end else begin
         result_in.refl = rnd[fdr_pkg::OutW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vp_ff           <= 1'b0;
         vd_ff           <= 1'b0;
         vq_ff           <= 1'b0;
         result_ff.valid <= 1'b0;
      end else if (en) begin
         vp_ff     <= cos.valid;
         tp_ff     <= cos.tir;
         pa_ff     <= cos.nt * cos.c;
         pb_ff     <= cos.ni * cos.ct;
         pc_ff     <= cos.ni * cos.c;
         pd_ff     <= cos.nt * cos.ct;
         vd_ff     <= vp_ff;
         td_ff     <= tp_ff;
         diff_s_ff <= diff_s_in;
         diff_p_ff <= diff_p_in;
         den_s_ff  <= den_s_in;
         den_p_ff  <= den_p_in;
         vq_ff     <= div_ff[fdr_pkg::RqW-1].valid;
         tq_ff     <= div_ff[fdr_pkg::RqW-1].tir;
         sqs_ff    <= qs * qs;
         sqp_ff    <= qp * qp;
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule

// ===== design/fresnel_dielectric_reflectance_unit.sv =====
// Top level of the unpolarized dielectric Fresnel reflectance unit.
// Depends on fdr_pkg, fdr_front, fdr_transcos and fdr_ratio.
//
// Usage:
// The req channel carries the signed Q2.14 cosine of the incidence angle; the
// rsp channel returns the Q1.15 reflectance and the total reflection flag, one
// result per transfer, in order. Both channels use valid and ready.
// The two refractive indices are Q4.12 registers on the csr port at byte
// addresses 0 (incident) and 4 (transmit); write them only while idle.
// The datapath is a 77-stage pipeline: 4 front stages, a 29-stage divider and a
// 15-stage square root for the transmitted cosine, then two parallel 25-stage
// dividers with product, difference, square and rounding stages. A new transfer
// is taken every cycle while the pipeline is not frozen.
// A two-entry output buffer follows the pipeline. When the receiver stalls,
// the buffer fills, and once it holds two results the whole pipeline freezes
// and req_ready drops until a result is taken.
// Reset clears all valid bits and the buffer and sets both indices to 1.0.
module fresnel_dielectric_reflectance_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic signed [fdr_pkg::CosW-1:0]    req_cos_incident,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [fdr_pkg::OutW-1:0]           rsp_reflectance,
   output logic                               rsp_total_reflection,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [fdr_pkg::AddrW-1:0]          csr_paddr,
   input  logic [fdr_pkg::DataW-1:0]          csr_pwdata,
   output logic [fdr_pkg::DataW-1:0]          csr_prdata,
   output logic                               csr_pready
);

   logic [fdr_pkg::IdxW-1:0] ni_ff, nt_ff;
   logic                     csr_wr;
   logic                     en;
   logic                     push, pop;
   fdr_pkg::front_type       front;
   fdr_pkg::cos_type         cos;
   fdr_pkg::result_type      result;
   fdr_pkg::result_type      head_ff, head_in, tail_ff, tail_in;
   logic [1:0]               cnt_ff, cnt_in;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      unique case (csr_paddr[fdr_pkg::AddrW-1])
         fdr_pkg::RegIncident: csr_prdata = fdr_pkg::DataW'(ni_ff);
         fdr_pkg::RegTransmit: csr_prdata = fdr_pkg::DataW'(nt_ff);
         default:              csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ni_ff <= fdr_pkg::IndexReset;
         nt_ff <= fdr_pkg::IndexReset;
      end else if (csr_wr) begin
         unique case (csr_paddr[fdr_pkg::AddrW-1])
            fdr_pkg::RegIncident: ni_ff <= csr_pwdata[fdr_pkg::IdxW-1:0];
            fdr_pkg::RegTransmit: nt_ff <= csr_pwdata[fdr_pkg::IdxW-1:0];
            default: ;
         endcase
      end
   end

   assign en        = (cnt_ff != 2'd2);
   assign req_ready = en;

   fdr_front u_front (
      .clock          (clock),
      .reset          (reset),
      .en             (en),
      .in_valid       (req_valid),
      .cos_in         (req_cos_incident),
      .index_incident (ni_ff),
      .index_transmit (nt_ff),
      .front          (front)
   );

   fdr_transcos u_transcos (
      .clock (clock),
      .reset (reset),
      .en    (en),
      .front (front),
      .cos   (cos)
   );

   fdr_ratio u_ratio (
      .clock  (clock),
      .reset  (reset),
      .en     (en),
      .cos    (cos),
      .result (result)
   );

   assign push = en && result.valid;
   assign pop  = rsp_valid && rsp_ready;

   always_comb begin
      head_in = head_ff;
      tail_in = tail_ff;
      if (pop && cnt_ff == 2'd2) begin
         head_in = tail_ff;
      end else if (push && (cnt_ff == 2'd0 || (cnt_ff == 2'd1 && pop))) begin
         head_in = result;
      end
      if (push && cnt_ff == 2'd1 && !pop) begin
         tail_in = result;
      end
      cnt_in = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff  <= cnt_in;
         head_ff <= head_in;
         tail_ff <= tail_in;
      end
   end

   assign rsp_valid            = (cnt_ff != 2'd0);
   assign rsp_reflectance      = head_ff.refl;
   assign rsp_total_reflection = head_ff.tir;

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3)
      else $error("output buffer count out of range");

   a_tir_one: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_total_reflection |-> rsp_reflectance == fdr_pkg::OneQ15)
      else $error("total reflection without full reflectance");

   a_refl_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_reflectance <= fdr_pkg::OneQ15)
      else $error("reflectance above one");

   a_unfreeze: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd2 && pop) |=> req_ready)
      else $error("pipeline stays frozen after a result transfer");

endmodule

// ===== dv/fdr_checker.sv =====
// Result checker for the dielectric reflectance unit: predicts each transfer
// from the current indices and compares results in order. Depends on fdr_pkg.
module fdr_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_ready,
   input  logic signed [fdr_pkg::CosW-1:0] req_cos_incident,
   input  logic                            rsp_valid,
   input  logic                            rsp_ready,
   input  logic [fdr_pkg::OutW-1:0]        rsp_reflectance,
   input  logic                            rsp_total_reflection,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [fdr_pkg::AddrW-1:0]       csr_paddr,
   input  logic [fdr_pkg::DataW-1:0]       csr_pwdata,
   input  logic                            csr_pready,
   output int                              fail_count,
   output int                              pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [fdr_pkg::AddrW-1:0] AddrIncident = 3'd0;
   localparam logic [fdr_pkg::AddrW-1:0] AddrTransmit = 3'd4;

   typedef struct {
      logic [fdr_pkg::OutW-1:0] refl;
      logic                     tir;
   } refl_item_type;

   refl_item_type            expected_q[$];
   logic [fdr_pkg::IdxW-1:0] n_inc;
   logic [fdr_pkg::IdxW-1:0] n_trn;

   function automatic logic [63:0] isqrt64(logic [63:0] v);
      logic [63:0] res;
      logic [63:0] b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v = v - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   function automatic logic [63:0] ratio_squared(logic [63:0] x, logic [63:0] y);
      logic [63:0] den;
      logic [63:0] diff;
      logic [63:0] q;
      den = x + y;
      diff = (x > y) ? x - y : y - x;
      if (den == 0) return 64'd1 << 48;
      q = (diff << 24) / den;
      return q * q;
   endfunction

   function automatic refl_item_type fresnel(logic signed [fdr_pkg::CosW-1:0] cosv,
                                             logic [fdr_pkg::IdxW-1:0] a,
                                             logic [fdr_pkg::IdxW-1:0] b);
      refl_item_type o;
      int            v;
      logic [63:0]   ni, nt, c, s2, lhs, rhs, ct, sum, r;
      v = cosv;
      ni = a;
      nt = b;
      if (v > 16384) v = 16384;
      if (v < -16384) v = -16384;
      if (v < 0) begin
         ni = b;
         nt = a;
         c = -v;
      end else begin
         c = v;
      end
      s2 = (64'd1 << 28) - c * c;
      lhs = s2 * (ni * ni);
      rhs = (nt * nt) << 28;
      if (lhs >= rhs) begin
         o.refl = fdr_pkg::OneQ15;
         o.tir = 1'b1;
         return o;
      end
      ct = isqrt64((rhs - lhs) / (nt * nt));
      sum = ratio_squared(nt * c, ni * ct) + ratio_squared(ni * c, nt * ct);
      r = (sum + (64'd1 << 33)) >> 34;
      if (r > 32768) r = 32768;
      o.refl = r[fdr_pkg::OutW-1:0];
      o.tir = 1'b0;
      return o;
   endfunction

   assign pending_count = expected_q.size();

   always @(posedge clock) begin
      refl_item_type e;
      if (reset) begin
         n_inc <= fdr_pkg::IndexReset;
         n_trn <= fdr_pkg::IndexReset;
         fail_count <= 0;
         expected_q.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            if (csr_paddr == AddrIncident) n_inc <= csr_pwdata[fdr_pkg::IdxW-1:0];
            else if (csr_paddr == AddrTransmit) n_trn <= csr_pwdata[fdr_pkg::IdxW-1:0];
         end
         if (req_valid && req_ready)
            expected_q.push_back(fresnel(req_cos_incident, n_inc, n_trn));
         if (rsp_valid && rsp_ready) begin
            if (expected_q.size() == 0) begin
               if (fail_count < 10)
                  $display("ERROR: unexpected result transfer refl=%0d tir=%0b",
                           rsp_reflectance, rsp_total_reflection);
               fail_count <= fail_count + 1;
            end else begin
               e = expected_q.pop_front();
               if (e.refl !== rsp_reflectance || e.tir !== rsp_total_reflection) begin
                  if (fail_count < 10)
                     $display("ERROR: expected refl=%0d tir=%0b, got refl=%0d tir=%0b",
                              e.refl, e.tir, rsp_reflectance, rsp_total_reflection);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end
endmodule

// ===== dv/tb_fresnel_dielectric_reflectance_unit.sv =====
// Top of the dielectric reflectance unit testbench: clock, reset, stimulus and
// verdict. Depends on fdr_pkg, fdr_checker and the unit itself.
module tb_fresnel_dielectric_reflectance_unit;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [fdr_pkg::AddrW-1:0] AddrIncident = 3'd0;
   localparam logic [fdr_pkg::AddrW-1:0] AddrTransmit = 3'd4;
   localparam logic [fdr_pkg::AddrW-1:0] AddrUnused = 3'd0;

   logic                              clock;
   logic                              reset;
   logic                              req_valid;
   logic                              req_ready;
   logic signed [fdr_pkg::CosW-1:0]   req_cos_incident;
   logic                              rsp_valid;
   logic                              rsp_ready;
   logic [fdr_pkg::OutW-1:0]          rsp_reflectance;
   logic                              rsp_total_reflection;
   logic                              csr_psel;
   logic                              csr_penable;
   logic                              csr_pwrite;
   logic [fdr_pkg::AddrW-1:0]         csr_paddr;
   logic [fdr_pkg::DataW-1:0]         csr_pwdata;
   logic [fdr_pkg::DataW-1:0]         csr_prdata;
   logic                              csr_pready;
   int                                fail_count;
   int                                pending_count;
   bit                                busy_phase;

   fresnel_dielectric_reflectance_unit dut (.*);

   fdr_checker checker_i (.*);

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #4000000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   always @(posedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else rsp_ready <= busy_phase || ($urandom_range(99) >= 25);
   end

   task automatic csr_write(logic [fdr_pkg::AddrW-1:0] addr,
                            logic [fdr_pkg::DataW-1:0] data);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic send_cos(logic signed [fdr_pkg::CosW-1:0] v);
      while (!busy_phase && $urandom_range(99) < 25) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cos_incident <= v;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (5) @(posedge clock);
   endtask

   task automatic set_indices(logic [fdr_pkg::IdxW-1:0] a, logic [fdr_pkg::IdxW-1:0] b);
      csr_write(AddrIncident, {16'h0, a});
      csr_write(AddrTransmit, {16'($urandom_range(65535)), b});
   endtask

   function automatic logic signed [fdr_pkg::CosW-1:0] pick_cos();
      case ($urandom_range(5))
         0: return fdr_pkg::CosW'($urandom);
         1: return fdr_pkg::CosW'(int'($urandom_range(800)) - 400);
         2: return fdr_pkg::CosW'(16384 - int'($urandom_range(300)));
         3: return fdr_pkg::CosW'(-16384 + int'($urandom_range(300)));
         default: return fdr_pkg::CosW'(int'($urandom_range(32768)) - 16384);
      endcase
   endfunction

   logic [fdr_pkg::IdxW-1:0] idx_a [7] = '{16'd4096, 16'd1, 16'd65535, 16'd6144,
      16'd5448, 16'd4096, 16'd9830};
   logic [fdr_pkg::IdxW-1:0] idx_b [7] = '{16'd4096, 16'd65535, 16'd1, 16'd4096,
      16'd4096, 16'd6144, 16'd4915};
   logic signed [fdr_pkg::CosW-1:0] directed [14] = '{16'sh0000, 16'sh4000, 16'shC000,
      16'sh7FFF, 16'sh8000, 16'sh4001, 16'shBFFF, 16'sh0001, 16'shFFFF, 16'sh2000,
      16'shE000, 16'sh5555, 16'shAAAA, 16'sh3FFF};

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_cos_incident = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = AddrUnused;
      csr_pwdata = '0;
      busy_phase = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (directed[i]) send_cos(directed[i]);
      drain();
      for (int p = 0; p < 8; p++) begin
         if (p < 7) set_indices(idx_a[p], idx_b[p]);
         else set_indices(16'($urandom_range(65535, 1)), 16'($urandom_range(65535, 1)));
         busy_phase = (p == 3);
         for (int i = 0; i < 95; i++) begin
            send_cos(pick_cos());
            if (p == 1 && i == 0) begin
               req_valid <= 1'b0;
               drain();
               csr_write(AddrTransmit, 32'd0);
            end
         end
         drain();
      end
      busy_phase = 1'b0;
      repeat (100) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end
endmodule
